@@ design/vbb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbb_pkg
// Shared widths and payload types for the vertex bounding box block.
// ----------------------------------------------------------------------------
package vbb_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int NUM_AXES    = 3;
    localparam int ROOT_W      = COORD_WIDTH;
    localparam int RAD_W       = 2 * COORD_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic signed [COORD_WIDTH-1:0] vertex_z;
        logic                          last_vertex;
    } t_vbb_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] min_x;
        logic signed [COORD_WIDTH-1:0] min_y;
        logic signed [COORD_WIDTH-1:0] min_z;
        logic signed [COORD_WIDTH-1:0] max_x;
        logic signed [COORD_WIDTH-1:0] max_y;
        logic signed [COORD_WIDTH-1:0] max_z;
        logic signed [COORD_WIDTH-1:0] mid_x;
        logic signed [COORD_WIDTH-1:0] mid_y;
        logic signed [COORD_WIDTH-1:0] mid_z;
        logic        [COORD_WIDTH-1:0] radius;
    } t_vbb_out;

endpackage
`default_nettype wire

@@ design/vbb_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbb_isqrt
// Iterative floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module vbb_isqrt
    import vbb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;

    logic [REM_W-1:0]  w_rem_t;
    logic [REM_W-1:0]  w_trial;
    logic              w_ge;

    assign w_rem_t = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial = {{(REM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
    assign w_ge    = (w_rem_t >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == '0)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_run) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_t - w_trial) : w_rem_t;
            r_root <= {r_root[ROOT_W-2:0], w_ge};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

@@ design/vertex_bounding_box.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_bounding_box
// Axis-aligned bounding box of a vertex set, with midpoint and sphere radius.
//
// Input: one vertex per transfer, taken at a clock edge with start high and
// busy low. Vertices that are not flagged last_vertex do not raise busy, so
// a set streams in at one vertex per cycle. The first vertex of a set seeds
// the box; later ones widen it.
// On the last vertex the block goes busy: it forms the midpoints and half
// extents, then the three squares on one shared multiplier, then the final
// sum, then the 24 one-bit steps of the square root unit, with hand-off
// registers between. The result is then loaded into o_result and held, with
// o_strobe high for one cycle, and busy drops in that same cycle, so the
// next set may start while the result is shown.
// Results cannot be held off; o_strobe is the only qualifier.
// Reset (synchronous, active low) drops busy and o_strobe and starts a fresh
// set.
// ----------------------------------------------------------------------------
module vertex_bounding_box
    import vbb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_vbb_in  i_item,
    output logic          busy,
    output t_vbb_out      o_result,
    output logic          o_strobe
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HALF = 5'b00010,
        S_SQ   = 5'b00100,
        S_ACC  = 5'b01000,
        S_ROOT = 5'b10000
    } t_state;

    localparam logic [1:0] AXIS_LAST = 2'(NUM_AXES - 1);

    t_state                  r_state;
    t_state                  n_state;
    logic                    r_started;
    t_coord                  r_lo   [NUM_AXES];
    t_coord                  r_hi   [NUM_AXES];
    t_coord                  r_mid  [NUM_AXES];
    logic [COORD_WIDTH-1:0]  r_half [NUM_AXES];
    logic [1:0]              r_axis;
    logic [RAD_W-1:0]        r_prod;
    logic [RAD_W-1:0]        r_acc;
    logic                    r_sq_start;

    logic                    w_accept;
    t_coord                  w_v    [NUM_AXES];
    logic signed [COORD_WIDTH:0] w_sum  [NUM_AXES];
    logic [COORD_WIDTH:0]    w_diff [NUM_AXES];
    logic [COORD_WIDTH-1:0]  w_hsel;
    logic [RAD_W-1:0]        w_prod;
    logic                    w_sq_done;
    logic [ROOT_W-1:0]       w_root;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start & ~busy;

    assign w_v[0] = i_item.vertex_x;
    assign w_v[1] = i_item.vertex_y;
    assign w_v[2] = i_item.vertex_z;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_sum[a]  = $signed({r_lo[a][COORD_WIDTH-1], r_lo[a]})
                      + $signed({r_hi[a][COORD_WIDTH-1], r_hi[a]});
            w_diff[a] = {r_hi[a][COORD_WIDTH-1], r_hi[a]}
                      - {r_lo[a][COORD_WIDTH-1], r_lo[a]}
                      + (COORD_WIDTH+1)'(1);
        end
    end

    assign w_hsel = r_half[r_axis];
    assign w_prod = w_hsel * w_hsel;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_item.last_vertex) begin
                    n_state = S_HALF;
                end
            end
            S_HALF: begin
                n_state = S_SQ;
            end
            S_SQ: begin
                if (r_axis == AXIS_LAST) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_sq_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_started  <= 1'b0;
            r_sq_start <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sq_start <= (r_state == S_ACC);
            o_strobe   <= w_sq_done;
            if (w_accept) begin
                r_started <= ~i_item.last_vertex;
            end
        end
    end

    // running box
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (!r_started) begin
                    r_lo[a] <= w_v[a];
                    r_hi[a] <= w_v[a];
                end else begin
                    if (w_v[a] > r_hi[a]) begin
                        r_hi[a] <= w_v[a];
                    end
                    if (w_v[a] < r_lo[a]) begin
                        r_lo[a] <= w_v[a];
                    end
                end
            end
        end
    end

    // midpoint, half extent, sum of squares
    always_ff @(posedge i_clk) begin
        if (r_state == S_HALF) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_mid[a]  <= w_sum[a][COORD_WIDTH:1];
                r_half[a] <= w_diff[a][COORD_WIDTH:1];
            end
            r_axis <= '0;
        end else if (r_state == S_SQ) begin
            r_prod <= w_prod;
            r_acc  <= (r_axis == '0) ? '0 : (r_acc + r_prod);
            r_axis <= r_axis + 2'(1);
        end else if (r_state == S_ACC) begin
            r_acc <= r_acc + r_prod;
        end
    end

    vbb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_rad   (r_acc),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_sq_done) begin
            o_result.min_x  <= r_lo[0];
            o_result.min_y  <= r_lo[1];
            o_result.min_z  <= r_lo[2];
            o_result.max_x  <= r_hi[0];
            o_result.max_y  <= r_hi[1];
            o_result.max_z  <= r_hi[2];
            o_result.mid_x  <= r_mid[0];
            o_result.mid_y  <= r_mid[1];
            o_result.mid_z  <= r_mid[2];
            o_result.radius <= w_root;
        end
    end

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> ((r_hi[0] >= r_lo[0]) && (r_hi[1] >= r_lo[1])
                       && (r_hi[2] >= r_lo[2])))
        else $error("box corners out of order");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.last_vertex) |=> (r_state == S_HALF))
        else $error("last vertex did not start the closing sequence");

    a_strobe_from_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_ROOT))
        else $error("result strobe outside root phase");

    a_strobe_set_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !r_started)
        else $error("result strobe while a set is open");

endmodule
`default_nettype wire
